FILE: hw/rtl/svs_pkg.sv
// ---------------------------------------------------------------------------
// svs_pkg: shared types for the stream value sorter
// Word formats, cell link and control types, and the controller states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package svs_pkg;

	localparam int unsigned VALUE_W = 32;

	// One input word
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last_item;
	} item_word_t;

	// One result word
	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      last_out;
		logic                      overflow;
	} result_word_t;

	// Contents of one cell, as handed to its neighbors
	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] value;
	} cell_data_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic ins;    // insert the new value into the sorted row
		logic shift;  // move the row one cell toward the head
	} cell_ctrl_t;

	// Controller states
	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} svs_state_t;

endpackage

FILE: hw/rtl/stream_value_sorter.sv
// An accepted word, if the row is not full, takes its sorted place next cycle.
// Throughput: one word per cycle while a run is collected; after the last
// word the input stalls while the row drains, one result per cycle unless
// result_stall holds a valid result. A run of n held values gives n results.
// Reset clears the cell valid bits, the count, the drop flag and the output
// valid; stored values are not cleared.
// ---------------------------------------------------------------------------
// stream_value_sorter: collect a run of signed values and emit it sorted
// A row of DEPTH cells keeps the run in ascending order as it arrives; on
// the last word the row shifts out through the head cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stream_value_sorter #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  svs_pkg::item_word_t   item_data,
	output logic                  result_valid,
	input  logic                  result_stall,
	output svs_pkg::result_word_t result_data
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	svs_pkg::svs_state_t   state_q, state_d;
	logic [CNT_W-1:0]      count_q;
	logic                  dropped_q;
	logic                  result_valid_q;
	svs_pkg::result_word_t result_q;

	logic                  accept;
	logic                  full;
	logic                  drain_step;
	logic                  drain_end;
	svs_pkg::cell_ctrl_t   ctrl;

	svs_pkg::cell_data_t   cell_data [DEPTH];
	logic [DEPTH-1:0]      cell_lt;
	logic [DEPTH-1:0]      cell_valid;

	// Handshake and control
	assign full       = (count_q == CNT_W'(DEPTH));
	assign item_stall = (state_q == svs_pkg::ST_DRAIN);
	assign accept     = item_valid && !item_stall;
	assign drain_step = (state_q == svs_pkg::ST_DRAIN) && (!result_valid_q || !result_stall);
	assign drain_end  = drain_step && (count_q == CNT_W'(1));
	assign ctrl.ins   = accept && !full;
	assign ctrl.shift = drain_step;

	// Row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		svs_pkg::cell_data_t prev_data;
		logic                prev_lt;
		svs_pkg::cell_data_t next_data;

		if (i == 0) begin : g_head
			assign prev_data = '0;
			assign prev_lt   = 1'b0;
		end else begin : g_body
			assign prev_data = cell_data[i-1];
			assign prev_lt   = cell_lt[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_data = '0;
		end else begin : g_link
			assign next_data = cell_data[i+1];
		end

		svs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_value (item_data.value),
			.prev_data (prev_data),
			.prev_lt   (prev_lt),
			.next_data (next_data),
			.data      (cell_data[i]),
			.lt        (cell_lt[i])
		);

		assign cell_valid[i] = cell_data[i].valid;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svs_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			svs_pkg::ST_FILL: begin
				if (accept && item_data.last_item) begin
					state_d = svs_pkg::ST_DRAIN;
				end
			end
			svs_pkg::ST_DRAIN: begin
				if (drain_end) begin
					state_d = svs_pkg::ST_FILL;
				end
			end
			default: begin
				state_d = svs_pkg::ST_FILL;
			end
		endcase
	end

	// Held count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (ctrl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (drain_step) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept && full) begin
				dropped_q <= 1'b1;
			end else if (drain_end) begin
				dropped_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (drain_step) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_step) begin
			result_q.sorted_value <= cell_data[0].value;
			result_q.last_out     <= (count_q == CNT_W'(1));
			result_q.overflow     <= dropped_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// Checks
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("held count disagrees with occupied cells");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("held count above depth");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		drain_step |-> (count_q != '0) && cell_data[0].valid)
		else $error("drain step on empty row");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result_data)))
		else $error("stalled result word changed");

endmodule

FILE: hw/rtl/svs_cell.sv
// ---------------------------------------------------------------------------
// svs_cell: one cell of the insertion sorting row
// Holds one value. On insert it keeps its value, takes the value of the
// cell before it, or takes the new value; on shift it takes the next cell's.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svs_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  svs_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [svs_pkg::VALUE_W-1:0]  new_value,
	input  svs_pkg::cell_data_t                 prev_data,
	input  logic                                prev_lt,
	input  svs_pkg::cell_data_t                 next_data,
	output svs_pkg::cell_data_t                 data,
	output logic                                lt
);

	logic                               valid_q;
	logic signed [svs_pkg::VALUE_W-1:0] value_q;

	// New value goes before this cell's value (empty cells sit at the tail)
	assign lt = !valid_q || ($signed(new_value) < $signed(value_q));

	assign data.valid = valid_q;
	assign data.value = value_q;

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_data.valid;
		end else if (ctrl.ins && lt) begin
			valid_q <= prev_lt ? prev_data.valid : 1'b1;
		end
	end

	// Value, no reset needed
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_data.value;
		end else if (ctrl.ins && lt) begin
			value_q <= prev_lt ? prev_data.value : new_value;
		end
	end

endmodule
